/* rtl/core/smsort_pkg.sv */
// shared types and constants of the stable merge sorter
package smsort_pkg;

  localparam int unsigned DataW = 32;

  // what one cell shows its neighbors
  typedef struct packed {
    logic             valid;
    logic             gt;
    logic [DataW-1:0] data;
  } cell_link_t;

  // row-wide commands, the same for every cell
  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctrl_t;

endpackage

/* rtl/core/smsort_cell.sv */
// one cell of the sorting row: holds one element and compares it with the incoming beat
module smsort_cell import smsort_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [DataW-1:0] x_i,
  input  cell_link_t       left_i,
  input  cell_link_t       right_i,
  output cell_link_t       link_o
);

  logic             valid_q, valid_d;
  logic [DataW-1:0] data_q, data_d;
  logic             gt;

  // strictly greater keeps equal elements in arrival order
  assign gt = valid_q && ($signed(data_q) > $signed(x_i));

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.shift_out) begin
      valid_d = right_i.valid;
      data_d  = right_i.data;
    end else if (ctrl_i.insert && (gt || !valid_q)) begin
      if (left_i.gt) begin
        // left neighbor moves up into this cell
        valid_d = 1'b1;
        data_d  = left_i.data;
      end else if (left_i.valid) begin
        // insertion point
        valid_d = 1'b1;
        data_d  = x_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.gt    = gt;
  assign link_o.data  = data_q;

endmodule

/* rtl/core/stable_merge_sorter_top.sv */
// top level of the stable merge sorter: row of insertion cells plus load/drain control
//
// The block collects a run of signed 32-bit values, one beat per cycle, into a
// row of MAX_ITEMS cells that keeps them in ascending order as they arrive; the
// beat with last_in_i closes the run. The run is then sent out smallest first,
// one beat per cycle while out_ready_i is high, the row shifting toward cell 0
// on every output beat. Equal values leave in arrival order. The input is not
// ready while a run drains. Values that arrive with all cells full are dropped,
// and every output beat of that run then carries dropped_o. last_out_o marks
// the final beat of the run.
module stable_merge_sorter_top import smsort_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DataW-1:0] value_i,
  input  logic             last_in_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] sorted_value_o,
  output logic             last_out_o,
  output logic             dropped_o
);

  // control state
  localparam logic StLoad  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic       state_q, state_d;
  logic       drop_q, drop_d;
  logic       in_beat, out_beat, full;
  cell_ctrl_t ctrl;

  // links[g] is the output of cell g
  cell_link_t links [MAX_ITEMS];
  cell_link_t head_link, tail_link;

  // the left end acts like a valid, not-greater neighbor so cell 0 can take the beat
  assign head_link = '{valid: 1'b1, gt: 1'b0, data: '0};
  // past the right end the row is empty
  assign tail_link = '{valid: 1'b0, gt: 1'b0, data: '0};

  assign in_ready_o = (state_q == StLoad);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StDrain);
  assign out_beat    = out_valid_o && out_ready_i;

  // row is full when the last cell holds an element
  assign full = links[MAX_ITEMS-1].valid;

  assign ctrl.insert    = in_beat && !full;
  assign ctrl.shift_out = out_beat;

  genvar g;
  generate
    for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
      cell_link_t left_l, right_l;
      if (g == 0) begin : g_first
        assign left_l = head_link;
      end else begin : g_mid_l
        assign left_l = links[g-1];
      end
      if (g == MAX_ITEMS - 1) begin : g_last
        assign right_l = tail_link;
      end else begin : g_mid_r
        assign right_l = links[g+1];
      end
      smsort_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .x_i     (value_i),
        .left_i  (left_l),
        .right_i (right_l),
        .link_o  (links[g])
      );
    end
  endgenerate

  // cell 0 holds the smallest remaining element; the run ends when cell 1 is empty
  assign sorted_value_o = links[0].data;
  assign last_out_o     = !links[1].valid;
  assign dropped_o      = drop_q;

  always_comb begin
    state_d = state_q;
    drop_d  = drop_q;
    unique case (state_q)
      StLoad: begin
        if (in_beat) begin
          if (full) begin
            drop_d = 1'b1;
          end
          if (last_in_i) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (out_beat && last_out_o) begin
          state_d = StLoad;
          drop_d  = 1'b0;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      drop_q  <= drop_d;
    end
  end

  // a draining run always has its smallest element in cell 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> links[0].valid)
    else $error("drain with empty head cell");

  // a beat that finds the row full is flagged on the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && full) |=> dropped_o)
    else $error("dropped beat not flagged");

  // after the final output beat the row is empty and loading resumes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && last_out_o) |=> (in_ready_o && !links[0].valid && !dropped_o))
    else $error("row not empty after final beat");

  // a closing beat always leaves at least one element to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && last_in_i) |=> (out_valid_o && links[0].valid))
    else $error("run closed without elements");

endmodule

/* bench/tb_stable_merge_sorter_top.sv */
`timescale 1ns / 1ps
// testbench for the stable merge sorter: directed and random runs checked beat by beat
module tb_stable_merge_sorter_top;
  import smsort_pkg::*;

  // row depth of the block and how far the run is allowed to go
  localparam int unsigned Capacity    = 64;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned RandomItems = 260;
  localparam int unsigned DrainSlack  = 20;

  typedef logic signed [DataW-1:0] elem_t;

  // one output beat as the block should present it
  typedef struct packed {
    elem_t value;
    logic  last;
    logic  drop;
  } sorted_beat_t;

  // one row of the directed part; typed rows carry their own expected value
  typedef struct packed {
    elem_t value;
    logic  last;
    logic  typed;
    elem_t typed_value;
  } stim_row_t;

  // clock, reset and the block's inputs, all known from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [DataW-1:0] value_i     = '0;
  logic             last_in_i   = 1'b0;
  logic             out_ready_i = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [DataW-1:0] sorted_value_o;
  logic             last_out_o;
  logic             dropped_o;

  // directed runs: single-element runs at the extremes and around zero are typed
  // in, the rest go through the sorter model
  stim_row_t dir_rows [22] = '{
    // single-element runs: the value comes straight back
    '{32'sh7FFFFFFF, 1'b1, 1'b1, 32'sh7FFFFFFF},
    '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000},
    '{32'sh00000000, 1'b1, 1'b1, 32'sh00000000},
    '{32'shFFFFFFFF, 1'b1, 1'b1, 32'shFFFFFFFF},
    // two elements in falling order
    '{32'sd5,        1'b0, 1'b0, 32'sd0},
    '{-32'sd5,       1'b1, 1'b0, 32'sd0},
    // both extremes mixed with values around zero
    '{32'sh7FFFFFFF, 1'b0, 1'b0, 32'sd0},
    '{32'sh80000000, 1'b0, 1'b0, 32'sd0},
    '{32'sd0,        1'b0, 1'b0, 32'sd0},
    '{-32'sd1,       1'b0, 1'b0, 32'sd0},
    '{32'sd1,        1'b1, 1'b0, 32'sd0},
    // repeated keys, interleaved
    '{32'sd3,        1'b0, 1'b0, 32'sd0},
    '{32'sd3,        1'b0, 1'b0, 32'sd0},
    '{-32'sd2,       1'b0, 1'b0, 32'sd0},
    '{32'sd3,        1'b0, 1'b0, 32'sd0},
    '{-32'sd2,       1'b1, 1'b0, 32'sd0},
    // already in order
    '{32'sd1,        1'b0, 1'b0, 32'sd0},
    '{32'sd2,        1'b0, 1'b0, 32'sd0},
    '{32'sd3,        1'b1, 1'b0, 32'sd0},
    // all equal
    '{32'sd0,        1'b0, 1'b0, 32'sd0},
    '{32'sd0,        1'b0, 1'b0, 32'sd0},
    '{32'sd0,        1'b1, 1'b0, 32'sd0}
  };

  // sorter model state: the run so far in arrival order and its overflow mark
  elem_t        run_store[$];
  logic         run_overflow = 1'b0;
  sorted_beat_t run_sorted[$];      // beats released by the latest input beat
  sorted_beat_t pending_sorted[$];  // beats still owed by the block, oldest first

  // idling percentages, long receiver hold-off request and run bookkeeping
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          hold_req     = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned cycles       = 0;
  int unsigned errors       = 0;
  int unsigned beats_in     = 0;
  int unsigned runs_done    = 0;
  int unsigned beats_out    = 0;
  int unsigned drops_seen   = 0;

  stable_merge_sorter_top #(
    .MAX_ITEMS(Capacity)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .last_in_i     (last_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .last_out_o    (last_out_o),
    .dropped_o     (dropped_o)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // take one accepted value into the run; on the closing beat sort the run
  // stably and release it as expected beats
  function automatic void absorb_element(elem_t v, logic last);
    elem_t ordered[$];
    int    pos;
    int    k;
    run_sorted.delete();
    if (run_store.size() < Capacity) run_store.push_back(v);
    else run_overflow = 1'b1;
    if (!last) return;
    foreach (run_store[i]) begin
      // an equal key lands behind the ones that came earlier
      pos = ordered.size();
      for (k = 0; k < ordered.size(); k++) begin
        if (ordered[k] > run_store[i]) begin
          pos = k;
          break;
        end
      end
      ordered.insert(pos, run_store[i]);
    end
    foreach (ordered[i]) begin
      run_sorted.push_back('{ordered[i], logic'(i == ordered.size() - 1), run_overflow});
    end
    run_store.delete();
    run_overflow = 1'b0;
  endfunction

  // random key: mostly full-width, with a share of near-zero keys to force ties
  // and a share of the extremes
  function automatic elem_t pick_value();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel < 12) return elem_t'($urandom);
    if (sel < 17) return elem_t'(int'($urandom_range(6)) - 3);
    if (sel == 17) return 32'sh7FFFFFFF;
    if (sel == 18) return 32'sh80000000;
    return $urandom_range(1) ? -32'sd1 : 32'sd0;
  endfunction

  // offer one input beat, hold it until accepted, then update the model
  task automatic send_beat(elem_t v, logic last, logic typed, elem_t typed_value);
    int unsigned gap;
    // random idle gap; valid is only lowered here, never in the accepting step
    // of the same beat it rises for
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_in_i  <= last;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    absorb_element(v, last);
    if (typed) begin
      pending_sorted.push_back('{typed_value, 1'b1, 1'b0});
    end else begin
      foreach (run_sorted[i]) pending_sorted.push_back(run_sorted[i]);
    end
    beats_in++;
    if (last) runs_done++;
  endtask

  // compare one output beat with the oldest owed beat
  function automatic void check_sorted_beat();
    sorted_beat_t want;
    if (pending_sorted.size() == 0) begin
      $error("sorted beat with nothing owed: sorted_value %0d", $signed(sorted_value_o));
      errors++;
      return;
    end
    want = pending_sorted.pop_front();
    beats_out++;
    if (dropped_o === 1'b1) drops_seen++;
    if (sorted_value_o !== want.value) begin
      $error("sorted_value: expected %0d, got %0d", want.value, $signed(sorted_value_o));
      errors++;
    end
    if (last_out_o !== want.last) begin
      $error("last_out: expected %0b, got %0b", want.last, last_out_o);
      errors++;
    end
    if (dropped_o !== want.drop) begin
      $error("dropped: expected %0b, got %0b", want.drop, dropped_o);
      errors++;
    end
  endfunction

  // receiver: check at the edge, then pick ready for the next cycle; a hold-off
  // request keeps ready low for a long counted stretch
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) check_sorted_beat();
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus: reset, directed runs, then random runs in three idling phases
  initial begin
    int unsigned rnd_items;
    int unsigned run_idx;
    int unsigned run_len;
    bit          hold_done;
    rnd_items = 0;
    run_idx   = 0;
    hold_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase one: sender rarely idles, receiver stalls about half the time
    src_idle_pct = 6;
    snk_idle_pct = 52;
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].typed_value);
    end

    while (rnd_items < RandomItems) begin
      if (rnd_items < RandomItems / 3) begin
        src_idle_pct = 6;
        snk_idle_pct = 52;
      end else if (rnd_items < 2 * RandomItems / 3) begin
        // phase two: roles swapped
        src_idle_pct = 52;
        snk_idle_pct = 6;
      end else begin
        // phase three: nobody idles; one long receiver stall holds up a drain
        // and backs up the input
        src_idle_pct = 0;
        snk_idle_pct = 0;
        if (!hold_done) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
      end
      // mostly short runs; a run that exactly fills the row, one that loses
      // only its closing beat, and now and then one near capacity, up to 8 past it
      if (run_idx == 2) run_len = Capacity;
      else if (run_idx == 5) run_len = Capacity + 1;
      else if (run_idx % 9 == 8) run_len = $urandom_range(Capacity + 8, Capacity - 4);
      else run_len = $urandom_range(12, 1);
      for (int k = 1; k <= run_len; k++) begin
        send_beat(pick_value(), logic'(k == run_len), 1'b0, 32'sd0);
      end
      rnd_items += run_len;
      run_idx++;
    end
    in_valid_i <= 1'b0;

    while (pending_sorted.size() != 0) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);

    $display("sorted %0d runs from %0d input beats; %0d output beats checked",
             runs_done, beats_in, beats_out);
    $display("%0d output beats carried the overflow mark", drops_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
